>>> src/jtvs_pkg.sv
// Package: shared types, constants and limit-step functions for the velocity shaper.
`default_nettype none
package jtvs_pkg;

  localparam int unsigned AxisW   = 16;
  localparam int unsigned SpeedW  = 16;
  localparam int unsigned DzW     = 15;
  localparam int unsigned VelW    = 17;
  localparam int unsigned ModeW   = 3;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDatW = 16;
  localparam int unsigned TickW   = 16;
  localparam int unsigned ProdW   = 2 * SpeedW;
  localparam int unsigned DivCntW = $clog2(ProdW);

  localparam logic [TickW-1:0]   TIMEOUT_TICKS = 16'd10;
  localparam logic [AxisW:0]     FULL_SCALE    = 17'd32768;

  localparam logic [ModeW-1:0]   MODE_RESET    = 3'd1;
  localparam logic [DzW-1:0]     DZ_RESET      = 15'd3277;
  localparam logic [SpeedW-1:0]  MIN_RESET     = 16'd410;
  localparam logic [SpeedW-1:0]  MAX_RESET     = 16'd4096;
  localparam logic [SpeedW-1:0]  STEP_RESET    = 16'd410;

  localparam logic [CfgIdxW-1:0] CFG_MODE      = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_DEADZONE  = 4'd1;
  localparam logic [CfgIdxW-1:0] CFG_LIN_MIN   = 4'd2;
  localparam logic [CfgIdxW-1:0] CFG_LIN_MAX   = 4'd3;
  localparam logic [CfgIdxW-1:0] CFG_LIN_STEP  = 4'd4;
  localparam logic [CfgIdxW-1:0] CFG_ANG_MIN   = 4'd5;
  localparam logic [CfgIdxW-1:0] CFG_ANG_MAX   = 4'd6;
  localparam logic [CfgIdxW-1:0] CFG_ANG_STEP  = 4'd7;

  typedef enum logic [1:0] {
    LN_IDLE,
    LN_MUL,
    LN_DIV,
    LN_FIN
  } lane_state_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_CALC,
    ST_SEND,
    ST_ZERO
  } ctrl_state_e;

  typedef struct packed {
    logic                    invert;
    logic [DzW-1:0]          deadzone;
    logic [SpeedW-1:0]       minimum;
    logic [SpeedW-1:0]       limit;
  } lane_cfg_t;

  function automatic logic [SpeedW-1:0] step_up(input logic [SpeedW-1:0] lim,
                                                input logic [SpeedW-1:0] step,
                                                input logic [SpeedW-1:0] top);
    logic [SpeedW:0] s;
    s = {1'b0, lim} + {1'b0, step};
    return (s < {1'b0, top}) ? s[SpeedW-1:0] : top;
  endfunction

  function automatic logic [SpeedW-1:0] step_down(input logic [SpeedW-1:0] lim,
                                                  input logic [SpeedW-1:0] step,
                                                  input logic [SpeedW-1:0] bottom);
    logic signed [SpeedW:0] s;
    s = $signed({1'b0, lim}) - $signed({1'b0, step});
    return (s > $signed({1'b0, bottom})) ? s[SpeedW-1:0] : bottom;
  endfunction

endpackage
`default_nettype wire

>>> src/jtvs_lane.sv
// Lane: deadzone and rescale of one axis with a multiplier and a bit-serial divider.
`default_nettype none
module jtvs_lane
  import jtvs_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic signed [AxisW-1:0] axis_i,
  input  wire lane_cfg_t               cfg_i,
  output logic                         done_o,
  output logic signed [VelW-1:0]       res_o
);

  lane_state_e state_q, state_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic done_q, done_d;

  logic [SpeedW-1:0] diff_q, rabs_q, den_q, min_q;
  logic              rneg_q, aneg_q, inside_q;
  logic [ProdW-1:0]  prod_q, prod_d;
  logic [SpeedW-1:0] rem_q, rem_d, quo_q, quo_d;
  logic signed [VelW-1:0] res_q, res_d;

  logic signed [AxisW:0] a_ext, a_inv, a_mag, rng, rng_abs;
  logic [AxisW:0]        den_w;
  logic                  inside_w;
  logic [SpeedW:0]       trial, trial_sub;
  logic                  ge;
  logic signed [VelW-1:0] q_s, out_s;

  always_comb begin
    a_ext    = {axis_i[AxisW-1], axis_i};
    a_inv    = cfg_i.invert ? -a_ext : a_ext;
    a_mag    = a_inv[AxisW] ? -a_inv : a_inv;
    inside_w = a_mag[AxisW-1:0] <= {1'b0, cfg_i.deadzone};
    rng      = $signed({1'b0, cfg_i.limit}) - $signed({1'b0, cfg_i.minimum});
    rng_abs  = rng[SpeedW] ? -rng : rng;
    den_w    = FULL_SCALE - {2'b00, cfg_i.deadzone};
  end

  always_comb begin
    trial     = {rem_q, prod_q[ProdW-1]};
    ge        = trial >= {1'b0, den_q};
    trial_sub = trial - {1'b0, den_q};
    q_s       = rneg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
    out_s     = $signed({1'b0, min_q}) + q_s;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    prod_d  = prod_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    res_d   = res_q;
    done_d  = 1'b0;
    case (state_q)
      LN_IDLE: begin
        if (start_i) begin
          state_d = LN_MUL;
        end
      end
      LN_MUL: begin
        prod_d  = diff_q * rabs_q;
        rem_d   = '0;
        quo_d   = '0;
        cnt_d   = '1;
        state_d = LN_DIV;
      end
      LN_DIV: begin
        rem_d  = ge ? trial_sub[SpeedW-1:0] : trial[SpeedW-1:0];
        quo_d  = {quo_q[SpeedW-2:0], ge};
        prod_d = {prod_q[ProdW-2:0], 1'b0};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = LN_FIN;
        end
      end
      LN_FIN: begin
        if (inside_q) begin
          res_d = '0;
        end else if (aneg_q) begin
          res_d = -out_s;
        end else begin
          res_d = out_s;
        end
        done_d  = 1'b1;
        state_d = LN_IDLE;
      end
      default: begin
        state_d = LN_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LN_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == LN_IDLE && start_i) begin
      diff_q   <= a_mag[AxisW-1:0] - {1'b0, cfg_i.deadzone};
      rabs_q   <= rng_abs[SpeedW-1:0];
      rneg_q   <= rng[SpeedW];
      aneg_q   <= a_inv[AxisW];
      inside_q <= inside_w;
      den_q    <= den_w[SpeedW-1:0];
      min_q    <= cfg_i.minimum;
    end
    prod_q <= prod_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    res_q  <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
`default_nettype wire

>>> src/joystick_teleop_velocity_shaper_top.sv
// Top level: configuration, button and watchdog state, two axis lanes and output merge.
//
// Usage: joystick samples and watchdog ticks enter on the in channel
// (valid/ready); velocity commands leave on the out channel (valid/ready).
// Registers are written through the cfg channel, always ready; the user
// must write them only while idle, which the block does not enforce.
// A sample that is enabled starts the linear and angular lanes together;
// each lane captures its operands, does a 16x16 multiply and a restoring
// divide at one quotient bit per cycle, then forms the result. No new
// transaction is taken until that result has entered the output register.
// A zero command (disabled sample or watchdog timeout) uses no lane.
// The output register holds a result until the receiver takes it; while
// it is full the block may still take a transaction, and a new result waits
// in the lanes until the output register frees.
// Reset loads the register defaults, sets both limits to their maximum and
// clears the button history and watchdog state.
`default_nettype none
module joystick_teleop_velocity_shaper_top
  import jtvs_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [CfgDatW-1:0]      cfg_data_i,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic                    command_i,
  input  wire logic                    enable_left_i,
  input  wire logic                    enable_right_i,
  input  wire logic                    linear_up_i,
  input  wire logic                    linear_down_i,
  input  wire logic                    angular_up_i,
  input  wire logic                    angular_down_i,
  input  wire logic signed [AxisW-1:0] linear_axis_i,
  input  wire logic signed [AxisW-1:0] angular_axis_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic signed [VelW-1:0]       linear_velocity_o,
  output logic signed [VelW-1:0]       angular_velocity_o
);

  logic [ModeW-1:0]  mode_q;
  logic [DzW-1:0]    dz_q;
  logic [SpeedW-1:0] lin_min_q, lin_max_q, lin_step_q;
  logic [SpeedW-1:0] ang_min_q, ang_max_q, ang_step_q;

  logic [SpeedW-1:0] lin_lim_q, lin_lim_d, ang_lim_q, ang_lim_d;
  logic [3:0]        prev_q, prev_d;
  logic              zsent_q, zsent_d, seen_q, seen_d;
  logic [TickW-1:0]  ticks_q, ticks_d;
  ctrl_state_e       state_q, state_d;

  logic signed [AxisW-1:0] lin_axis_q, ang_axis_q;

  logic                   out_valid_q, out_valid_d;
  logic signed [VelW-1:0] lin_vel_q, lin_vel_d, ang_vel_q, ang_vel_d;

  logic                   accept, cfg_wr, out_free, lane_start, enabled;
  logic [3:0]             now, rise;
  logic [SpeedW-1:0]      lin_a, ang_a;
  logic [TickW-1:0]       ticks_inc;
  lane_cfg_t              lin_cfg, ang_cfg;
  logic                   lin_done, ang_done;
  logic signed [VelW-1:0] lin_res, ang_res;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i & in_ready_o;
  assign out_free    = ~out_valid_q | out_ready_i;
  assign lane_start  = (state_q == ST_START);

  assign lin_cfg = '{invert: mode_q[1], deadzone: dz_q, minimum: lin_min_q, limit: lin_lim_q};
  assign ang_cfg = '{invert: mode_q[2], deadzone: dz_q, minimum: ang_min_q, limit: ang_lim_q};

  jtvs_lane u_lane_lin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lane_start),
    .axis_i  (lin_axis_q),
    .cfg_i   (lin_cfg),
    .done_o  (lin_done),
    .res_o   (lin_res)
  );

  jtvs_lane u_lane_ang (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lane_start),
    .axis_i  (ang_axis_q),
    .cfg_i   (ang_cfg),
    .done_o  (ang_done),
    .res_o   (ang_res)
  );

  always_comb begin
    now       = {angular_down_i, angular_up_i, linear_down_i, linear_up_i};
    rise      = now & ~prev_q;
    lin_a     = rise[0] ? step_up(lin_lim_q, lin_step_q, lin_max_q) : lin_lim_q;
    ang_a     = rise[2] ? step_up(ang_lim_q, ang_step_q, ang_max_q) : ang_lim_q;
    enabled   = ~mode_q[0] | (enable_left_i & enable_right_i);
    ticks_inc = (ticks_q == '1) ? ticks_q : ticks_q + 1'b1;
  end

  always_comb begin
    state_d     = state_q;
    lin_lim_d   = lin_lim_q;
    ang_lim_d   = ang_lim_q;
    prev_d      = prev_q;
    zsent_d     = zsent_q;
    seen_d      = seen_q;
    ticks_d     = ticks_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    lin_vel_d   = lin_vel_q;
    ang_vel_d   = ang_vel_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (command_i) begin
            if (seen_q) begin
              ticks_d = ticks_inc;
              if (ticks_inc > TIMEOUT_TICKS && !zsent_q) begin
                zsent_d = 1'b1;
                state_d = ST_ZERO;
              end
            end
          end else begin
            seen_d    = 1'b1;
            ticks_d   = '0;
            prev_d    = now;
            lin_lim_d = rise[1] ? step_down(lin_a, lin_step_q, lin_min_q) : lin_a;
            ang_lim_d = rise[3] ? step_down(ang_a, ang_step_q, ang_min_q) : ang_a;
            if (enabled) begin
              zsent_d = 1'b0;
              state_d = ST_START;
            end else if (!zsent_q) begin
              zsent_d = 1'b1;
              state_d = ST_ZERO;
            end
          end
        end
      end
      ST_START: begin
        state_d = ST_CALC;
      end
      ST_CALC: begin
        if (lin_done && ang_done) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            lin_vel_d   = lin_res;
            ang_vel_d   = ang_res;
            state_d     = ST_IDLE;
          end else begin
            state_d = ST_SEND;
          end
        end
      end
      ST_SEND: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          lin_vel_d   = lin_res;
          ang_vel_d   = ang_res;
          state_d     = ST_IDLE;
        end
      end
      ST_ZERO: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          lin_vel_d   = '0;
          ang_vel_d   = '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (cfg_wr && cfg_index_i == CFG_LIN_MAX) begin
      lin_lim_d = cfg_data_i;
    end
    if (cfg_wr && cfg_index_i == CFG_ANG_MAX) begin
      ang_lim_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_RESET;
      dz_q       <= DZ_RESET;
      lin_min_q  <= MIN_RESET;
      lin_max_q  <= MAX_RESET;
      lin_step_q <= STEP_RESET;
      ang_min_q  <= MIN_RESET;
      ang_max_q  <= MAX_RESET;
      ang_step_q <= STEP_RESET;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        CFG_MODE:     mode_q     <= cfg_data_i[ModeW-1:0];
        CFG_DEADZONE: dz_q       <= cfg_data_i[DzW-1:0];
        CFG_LIN_MIN:  lin_min_q  <= cfg_data_i;
        CFG_LIN_MAX:  lin_max_q  <= cfg_data_i;
        CFG_LIN_STEP: lin_step_q <= cfg_data_i;
        CFG_ANG_MIN:  ang_min_q  <= cfg_data_i;
        CFG_ANG_MAX:  ang_max_q  <= cfg_data_i;
        CFG_ANG_STEP: ang_step_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lin_lim_q   <= MAX_RESET;
      ang_lim_q   <= MAX_RESET;
      prev_q      <= '0;
      zsent_q     <= 1'b1;
      seen_q      <= 1'b0;
      ticks_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lin_lim_q   <= lin_lim_d;
      ang_lim_q   <= ang_lim_d;
      prev_q      <= prev_d;
      zsent_q     <= zsent_d;
      seen_q      <= seen_d;
      ticks_q     <= ticks_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      lin_axis_q <= linear_axis_i;
      ang_axis_q <= angular_axis_i;
    end
    lin_vel_q <= lin_vel_d;
    ang_vel_q <= ang_vel_d;
  end

  assign out_valid_o        = out_valid_q;
  assign linear_velocity_o  = lin_vel_q;
  assign angular_velocity_o = ang_vel_q;

endmodule
`default_nettype wire

>>> sim/tb_joystick_teleop_velocity_shaper_top.sv
// Testbench for the joystick velocity shaper: directed and random joystick traffic checked against a scoreboard.
`timescale 1ns / 1ps

module tb_joystick_teleop_velocity_shaper_top;
  import jtvs_pkg::*;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  localparam logic [3:0] BTN_LIN_UP = 4'b0001;
  localparam logic [3:0] BTN_LIN_DN = 4'b0010;
  localparam logic [3:0] BTN_ANG_UP = 4'b0100;
  localparam logic [3:0] BTN_ANG_DN = 4'b1000;

  localparam logic [ModeW-1:0] MODE_NEED_EN = 3'b001;
  localparam logic [ModeW-1:0] MODE_INV_LIN = 3'b010;
  localparam logic [ModeW-1:0] MODE_INV_ANG = 3'b100;

  localparam logic [CfgIdxW-1:0] REG_ORDER [8] = '{
    CFG_MODE, CFG_DEADZONE, CFG_LIN_MIN, CFG_LIN_MAX,
    CFG_LIN_STEP, CFG_ANG_MIN, CFG_ANG_MAX, CFG_ANG_STEP
  };

  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int          SETTLE_CYCLES = 64;
  localparam int          NUM_PHASES    = 8;
  localparam int          PHASE_ITEMS   = 178;

  typedef struct packed {
    logic                    cmd;
    logic                    en_l;
    logic                    en_r;
    logic                    lin_up;
    logic                    lin_dn;
    logic                    ang_up;
    logic                    ang_dn;
    logic signed [AxisW-1:0] lin_axis;
    logic signed [AxisW-1:0] ang_axis;
  } joy_item_t;

  typedef struct {
    logic signed [VelW-1:0] lin;
    logic signed [VelW-1:0] ang;
  } velocity_t;

  class velocity_scoreboard;
    logic [ModeW-1:0]  mode;
    logic [DzW-1:0]    dz;
    logic [SpeedW-1:0] lin_min, lin_max, lin_step;
    logic [SpeedW-1:0] ang_min, ang_max, ang_step;
    logic [SpeedW-1:0] lin_limit, ang_limit;
    logic [3:0]        last_buttons;
    bit                zero_sent;
    bit                sample_seen;
    logic [TickW-1:0]  tick_count;
    velocity_t         expected_cmds[$];
    int                errors;

    function new();
      mode = MODE_RESET;
      dz = DZ_RESET;
      lin_min = MIN_RESET;
      lin_max = MAX_RESET;
      lin_step = STEP_RESET;
      ang_min = MIN_RESET;
      ang_max = MAX_RESET;
      ang_step = STEP_RESET;
      lin_limit = MAX_RESET;
      ang_limit = MAX_RESET;
      last_buttons = '0;
      zero_sent = 1'b1;
      sample_seen = 1'b0;
      tick_count = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] data);
      case (idx)
        CFG_MODE:     mode = data[ModeW-1:0];
        CFG_DEADZONE: dz = data[DzW-1:0];
        CFG_LIN_MIN:  lin_min = data;
        CFG_LIN_MAX: begin
          lin_max = data;
          lin_limit = data;
        end
        CFG_LIN_STEP: lin_step = data;
        CFG_ANG_MIN:  ang_min = data;
        CFG_ANG_MAX: begin
          ang_max = data;
          ang_limit = data;
        end
        CFG_ANG_STEP: ang_step = data;
        default: ;
      endcase
    endfunction

    function logic [SpeedW-1:0] raise_limit(logic [SpeedW-1:0] lim, logic [SpeedW-1:0] step,
                                            logic [SpeedW-1:0] top);
      logic [SpeedW:0] sum;
      sum = {1'b0, lim} + {1'b0, step};
      return (sum < {1'b0, top}) ? sum[SpeedW-1:0] : top;
    endfunction

    function logic [SpeedW-1:0] lower_limit(logic [SpeedW-1:0] lim, logic [SpeedW-1:0] step,
                                            logic [SpeedW-1:0] bottom);
      int diff;
      diff = int'(lim) - int'(step);
      return (diff > int'(bottom)) ? diff[SpeedW-1:0] : bottom;
    endfunction

    function logic signed [VelW-1:0] shape_axis(logic signed [AxisW-1:0] axis, bit invert,
                                                logic [SpeedW-1:0] base,
                                                logic [SpeedW-1:0] lim);
      int     a;
      int     mag;
      int     v;
      longint q;
      a = axis;
      if (invert) a = -a;
      mag = (a < 0) ? -a : a;
      if (mag <= int'(dz)) return '0;
      q = longint'(mag - int'(dz)) * (longint'(lim) - longint'(base));
      q = q / longint'(32768 - int'(dz));
      v = int'(base) + int'(q);
      if (a < 0) v = -v;
      return v[VelW-1:0];
    endfunction

    function void send_zero();
      velocity_t z;
      if (zero_sent) return;
      z.lin = '0;
      z.ang = '0;
      expected_cmds.push_back(z);
      zero_sent = 1'b1;
    endfunction

    function void absorb_item(joy_item_t it);
      logic [3:0] now_b;
      logic [3:0] rise;
      bit         enabled;
      velocity_t  v;
      if (it.cmd == CMD_TICK) begin
        if (!sample_seen) return;
        if (tick_count != '1) tick_count++;
        if (tick_count > TIMEOUT_TICKS) send_zero();
        return;
      end
      sample_seen = 1'b1;
      tick_count = '0;
      now_b = {it.ang_dn, it.ang_up, it.lin_dn, it.lin_up};
      rise = now_b & ~last_buttons;
      if ((rise & BTN_LIN_UP) != 0) lin_limit = raise_limit(lin_limit, lin_step, lin_max);
      if ((rise & BTN_LIN_DN) != 0) lin_limit = lower_limit(lin_limit, lin_step, lin_min);
      if ((rise & BTN_ANG_UP) != 0) ang_limit = raise_limit(ang_limit, ang_step, ang_max);
      if ((rise & BTN_ANG_DN) != 0) ang_limit = lower_limit(ang_limit, ang_step, ang_min);
      last_buttons = now_b;
      enabled = ((mode & MODE_NEED_EN) == 0) || (it.en_l && it.en_r);
      if (!enabled) begin
        send_zero();
        return;
      end
      v.lin = shape_axis(it.lin_axis, (mode & MODE_INV_LIN) != 0, lin_min, lin_limit);
      v.ang = shape_axis(it.ang_axis, (mode & MODE_INV_ANG) != 0, ang_min, ang_limit);
      expected_cmds.push_back(v);
      zero_sent = 1'b0;
    endfunction

    function void match_command(logic signed [VelW-1:0] lin, logic signed [VelW-1:0] ang);
      velocity_t exp_v;
      if (expected_cmds.size() == 0) begin
        errors++;
        $display("%0t: unexpected command, expected none, actual lin %0d ang %0d",
                 $time, lin, ang);
        return;
      end
      exp_v = expected_cmds.pop_front();
      if (lin !== exp_v.lin) begin
        errors++;
        $display("%0t: linear_velocity expected %0d actual %0d", $time, exp_v.lin, lin);
      end
      if (ang !== exp_v.ang) begin
        errors++;
        $display("%0t: angular_velocity expected %0d actual %0d", $time, exp_v.ang, ang);
      end
    endfunction

    function int pending();
      return expected_cmds.size();
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CfgIdxW-1:0]      cfg_index_i = '0;
  logic [CfgDatW-1:0]      cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic                    command_i = 1'b0;
  logic                    enable_left_i = 1'b0;
  logic                    enable_right_i = 1'b0;
  logic                    linear_up_i = 1'b0;
  logic                    linear_down_i = 1'b0;
  logic                    angular_up_i = 1'b0;
  logic                    angular_down_i = 1'b0;
  logic signed [AxisW-1:0] linear_axis_i = '0;
  logic signed [AxisW-1:0] angular_axis_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [VelW-1:0]  linear_velocity_o;
  logic signed [VelW-1:0]  angular_velocity_o;

  logic [31:0]       cycle_count = '0;
  logic [3:0]        held_buttons = '0;
  logic [CfgDatW-1:0] reg_plan [8];

  velocity_scoreboard board = new();

  joystick_teleop_velocity_shaper_top i_dut (.*);

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL joystick_teleop_velocity_shaper_top");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    case (cycle_count[11:10])
      2'd0: out_ready_i <= 1'b1;
      2'd1: out_ready_i <= ($urandom_range(0, 1) == 0);
      2'd2: out_ready_i <= (cycle_count[4:0] < 5'd6);
      default: out_ready_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.match_command(linear_velocity_o, angular_velocity_o);
    end
  end

  function automatic joy_item_t joy(logic en, logic [3:0] btn, logic [AxisW-1:0] lin,
                                    logic [AxisW-1:0] ang);
    joy_item_t it;
    it.cmd = CMD_SAMPLE;
    it.en_l = en;
    it.en_r = en;
    {it.ang_dn, it.ang_up, it.lin_dn, it.lin_up} = btn;
    it.lin_axis = lin;
    it.ang_axis = ang;
    return it;
  endfunction

  function automatic joy_item_t make_tick();
    joy_item_t   it;
    logic [63:0] r;
    r = {$urandom, $urandom};
    it = r[$bits(joy_item_t)-1:0];
    it.cmd = CMD_TICK;
    return it;
  endfunction

  function automatic logic [AxisW-1:0] pick_axis(int dz);
    int v;
    case ($urandom_range(0, 11))
      0: v = -32768;
      1: v = 32767;
      2: v = 0;
      3, 4: begin
        v = dz + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      5: v = $urandom_range(0, 64) - 32;
      default: v = $urandom;
    endcase
    return v[AxisW-1:0];
  endfunction

  function automatic joy_item_t make_sample();
    joy_item_t it;
    for (int b = 0; b < 4; b++) begin
      if ($urandom_range(0, 4) == 0) held_buttons[b] = ~held_buttons[b];
    end
    it = joy(1'b1, held_buttons, pick_axis(board.dz), pick_axis(board.dz));
    if ($urandom_range(0, 4) == 0) begin
      it.en_l = 1'($urandom_range(0, 1));
      it.en_r = 1'($urandom_range(0, 1));
    end
    return it;
  endfunction

  task automatic push_item(input joy_item_t it, input int gap);
    in_valid_i <= 1'b1;
    command_i <= it.cmd;
    enable_left_i <= it.en_l;
    enable_right_i <= it.en_r;
    linear_up_i <= it.lin_up;
    linear_down_i <= it.lin_dn;
    angular_up_i <= it.ang_up;
    angular_down_i <= it.ang_dn;
    linear_axis_i <= it.lin_axis;
    angular_axis_i <= it.ang_axis;
    do @(posedge clk_i); while (!in_ready_o);
    board.absorb_item(it);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic program_regs();
    logic [CfgIdxW-1:0] idx;
    logic [CfgDatW-1:0] data;
    for (int k = 0; k <= 8; k++) begin
      if (k == 8) begin
        idx = CFG_ANG_STEP + 4'($urandom_range(1, 8));
        data = 16'($urandom);
      end else begin
        idx = REG_ORDER[k];
        data = reg_plan[k];
      end
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i <= data;
      do @(posedge clk_i); while (!cfg_ready_o);
      board.write_reg(idx, data);
    end
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic settle();
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic plan_phase(input int p);
    case (p)
      1: reg_plan = '{16'(MODE_NEED_EN | MODE_INV_LIN | MODE_INV_ANG), 16'd0, 16'd0,
                      16'd65535, 16'd65535, 16'd65535, 16'd0, 16'd1};
      2: reg_plan = '{16'd0, 16'd32767, 16'd65535, 16'd65535, 16'd1, 16'd0,
                      16'd65535, 16'd65535};
      default: begin
        reg_plan[CFG_MODE[2:0]] = 16'($urandom_range(0, 7));
        case ($urandom_range(0, 4))
          0: reg_plan[CFG_DEADZONE[2:0]] = 16'd0;
          1: reg_plan[CFG_DEADZONE[2:0]] = 16'($urandom_range(0, 32767));
          default: reg_plan[CFG_DEADZONE[2:0]] = 16'($urandom_range(0, 6000));
        endcase
        reg_plan[CFG_LIN_MIN[2:0]] = 16'($urandom_range(0, 1) ? $urandom_range(0, 2000)
                                                              : $urandom);
        reg_plan[CFG_LIN_MAX[2:0]] = 16'($urandom);
        reg_plan[CFG_LIN_STEP[2:0]] = 16'($urandom_range(0, 1) ? $urandom_range(1, 3000)
                                                               : $urandom_range(1, 65535));
        reg_plan[CFG_ANG_MIN[2:0]] = 16'($urandom_range(0, 1) ? $urandom_range(0, 2000)
                                                              : $urandom);
        reg_plan[CFG_ANG_MAX[2:0]] = 16'($urandom);
        reg_plan[CFG_ANG_STEP[2:0]] = 16'($urandom_range(0, 1) ? $urandom_range(1, 3000)
                                                               : $urandom_range(1, 65535));
      end
    endcase
  endtask

  task automatic run_phase(input int count, input bit steady);
    int        burst_left;
    int        tick_run;
    int        gap;
    joy_item_t it;
    burst_left = $urandom_range(1, 24);
    tick_run = 0;
    for (int i = 0; i < count; i++) begin
      if (tick_run > 0) begin
        it = make_tick();
        tick_run--;
      end else begin
        case ($urandom_range(0, 19))
          0: begin
            tick_run = $urandom_range(8, 13);
            it = make_tick();
          end
          1: it = make_tick();
          default: it = make_sample();
        endcase
      end
      gap = 0;
      if (i == count - 1) begin
        gap = 1;
      end else if (!steady) begin
        burst_left--;
        if (burst_left == 0) begin
          gap = $urandom_range(1, 16);
          burst_left = $urandom_range(1, 24);
        end
      end
      push_item(it, gap);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_item(make_tick(), 0);
    push_item(joy(1'b0, 4'b0000, 16'd1000, 16'd1000), 0);
    push_item(joy(1'b1, 4'b0000, 16'd0, 16'd0), 0);
    push_item(joy(1'b1, 4'b0000, 16'h7FFF, 16'h8000), 0);
    push_item(joy(1'b1, 4'b0000, 16'h8000, 16'h7FFF), 0);
    push_item(joy(1'b1, 4'b0000, 16'd3277, -16'sd3277), 0);
    push_item(joy(1'b1, 4'b0000, 16'd3278, -16'sd3278), 0);
    // hold the press while disabled: history still advances
    push_item(joy(1'b0, BTN_LIN_DN, 16'h7FFF, 16'h7FFF), 0);
    push_item(joy(1'b0, 4'b0000, 16'h7FFF, 16'h7FFF), 0);
    push_item(joy(1'b1, BTN_LIN_UP | BTN_ANG_DN, 16'h7FFF, 16'h7FFF), 0);
    push_item(joy(1'b1, 4'b0000, 16'h8000, 16'h8000), 0);
    push_item(joy(1'b1, BTN_LIN_DN | BTN_ANG_DN, 16'h7FFF, 16'h8001), 0);
    push_item(joy(1'b1, 4'b0000, 16'h4000, -16'sd16384), 0);
    push_item(joy(1'b1, BTN_LIN_UP | BTN_LIN_DN | BTN_ANG_UP | BTN_ANG_DN,
                  16'h7FFF, 16'h8000), 0);
    for (int k = 0; k < 12; k++) push_item(make_tick(), 0);
    push_item(joy(1'b1, 4'b0000, 16'h2000, 16'hE000), 1);
    settle();

    for (int p = 1; p <= NUM_PHASES; p++) begin
      plan_phase(p);
      program_regs();
      run_phase(PHASE_ITEMS, (p % 3) == 0);
      settle();
    end

    if (board.errors == 0 && board.pending() == 0) begin
      $display("PASS joystick_teleop_velocity_shaper_top");
    end else begin
      $display("FAIL joystick_teleop_velocity_shaper_top");
    end
    $finish;
  end

endmodule
